// ===== rtl/ncsl_pkg.sv =====
// Package for the nesting comment / delimited string lexer.
// Holds the status and phase codes, the character item type and character helpers.
// No dependencies; used by the interfaces, the lexer engine and the top level.
package ncsl_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_CONT    = 3'd0,
        ST_COMMENT = 3'd1,
        ST_STRING  = 3'd2,
        ST_BAD     = 3'd3,
        ST_END     = 3'd4,
        ST_LIMIT   = 3'd5
    } status_t;

    // Scanner phases
    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_C_OPEN    = 4'd1,
        PH_C_BODY    = 4'd2,
        PH_S_QUOTE   = 4'd3,
        PH_S_OPEN    = 4'd4,
        PH_S_IDENT   = 4'd5,
        PH_S_HEREDOC = 4'd6,
        PH_S_BRACKET = 4'd7,
        PH_S_CLOSEQ  = 4'd8
    } phase_t;

    // Class of the previous character inside a comment body
    typedef enum logic [1:0] {
        CL_NONE  = 2'd0,
        CL_SLASH = 2'd1,
        CL_PLUS  = 2'd2
    } prev_class_t;

    localparam int CH_W = 21;
    localparam int DCH_W = 7;

    // One input request
    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            at_end;
        logic            start_req;
        logic            comment_allowed;
        logic            string_allowed;
    } char_item_t;

    localparam logic [CH_W-1:0] CH_SLASH  = 21'h00002F;
    localparam logic [CH_W-1:0] CH_PLUS   = 21'h00002B;
    localparam logic [CH_W-1:0] CH_Q      = 21'h000071;
    localparam logic [CH_W-1:0] CH_QUOTE  = 21'h000022;
    localparam logic [CH_W-1:0] CH_NL     = 21'h00000A;
    localparam logic [CH_W-1:0] CH_LPAREN = 21'h000028;
    localparam logic [CH_W-1:0] CH_RPAREN = 21'h000029;
    localparam logic [CH_W-1:0] CH_LBRACK = 21'h00005B;
    localparam logic [CH_W-1:0] CH_RBRACK = 21'h00005D;
    localparam logic [CH_W-1:0] CH_LBRACE = 21'h00007B;
    localparam logic [CH_W-1:0] CH_RBRACE = 21'h00007D;
    localparam logic [CH_W-1:0] CH_LANGLE = 21'h00003C;
    localparam logic [CH_W-1:0] CH_RANGLE = 21'h00003E;

    // Bracket kind codes
    localparam logic [1:0] BK_PAREN = 2'd0;
    localparam logic [1:0] BK_BRACK = 2'd1;
    localparam logic [1:0] BK_BRACE = 2'd2;
    localparam logic [1:0] BK_ANGLE = 2'd3;

    function automatic logic [CH_W-1:0] open_char(input logic [1:0] kind);
        logic [CH_W-1:0] r;
        unique case (kind)
            BK_PAREN: r = CH_LPAREN;
            BK_BRACK: r = CH_LBRACK;
            BK_BRACE: r = CH_LBRACE;
            BK_ANGLE: r = CH_LANGLE;
            default:  r = CH_LPAREN;
        endcase
        return r;
    endfunction

    function automatic logic [CH_W-1:0] close_char(input logic [1:0] kind);
        logic [CH_W-1:0] r;
        unique case (kind)
            BK_PAREN: r = CH_RPAREN;
            BK_BRACK: r = CH_RBRACK;
            BK_BRACE: r = CH_RBRACE;
            BK_ANGLE: r = CH_RANGLE;
            default:  r = CH_RPAREN;
        endcase
        return r;
    endfunction

    // Identifier character: letters, digits, underscore
    function automatic logic ident_char(input logic [CH_W-1:0] c);
        return (c >= 21'h61 && c <= 21'h7A) || (c >= 21'h41 && c <= 21'h5A) ||
               (c >= 21'h30 && c <= 21'h39) || c == 21'h5F;
    endfunction

endpackage

// ===== rtl/ncsl_char_if.sv =====
// Character channel: valid/ready handshake carrying one character request.
// Depends on ncsl_pkg for the field widths.
interface ncsl_char_if;
    import ncsl_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            at_end;
    logic            start_req;
    logic            comment_allowed;
    logic            string_allowed;

    modport source (
        output valid, ch, at_end, start_req, comment_allowed, string_allowed,
        input  ready
    );
    modport sink (
        input  valid, ch, at_end, start_req, comment_allowed, string_allowed,
        output ready
    );
endinterface

// ===== rtl/ncsl_status_if.sv =====
// Status channel: valid/ready handshake carrying one 3-bit status.
// Depends on ncsl_pkg for the status type.
interface ncsl_status_if;
    import ncsl_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;

    modport source (
        output valid, status,
        input  ready
    );
    modport sink (
        input  valid, status,
        output ready
    );
endinterface

// ===== rtl/ncsl_lex_engine.sv =====
// Lexer engine: scan state, delimiter store and the one-character step logic.
// Depends on ncsl_pkg. State advances only on cycles where fire is high.
module ncsl_lex_engine #(
    parameter int MAX_DELIM_LEN = 32,
    parameter int DEPTH_BITS    = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  ncsl_pkg::char_item_t item,
    output ncsl_pkg::status_t   status
);
    import ncsl_pkg::*;

    localparam int IDX_W = (MAX_DELIM_LEN > 1) ? $clog2(MAX_DELIM_LEN) : 1;
    localparam int DL_W  = $clog2(MAX_DELIM_LEN + 1);
    localparam int MP_W  = $clog2(MAX_DELIM_LEN + 2);
    localparam int MPX_W = MP_W + 1;

    phase_t                phase_reg, phase_next;
    logic [DEPTH_BITS-1:0] depth_reg, depth_next;
    prev_class_t           prev_reg, prev_next;
    logic [1:0]            bkind_reg, bkind_next;
    logic [DL_W-1:0]       dlen_reg, dlen_next;
    logic [MP_W-1:0]       mpos_reg, mpos_next;
    logic [DCH_W-1:0]      exp_reg;

    // Delimiter identifier store
    logic [DCH_W-1:0]      delim_mem [MAX_DELIM_LEN];

    status_t               st;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [MP_W-1:0]       rd_pos;
    logic [IDX_W-1:0]      mem_raddr;
    logic [DL_W-1:0]       dlen_cur;
    logic [CH_W-1:0]       c;
    logic [CH_W-1:0]       expected;
    logic [MPX_W-1:0]      mpos_inc;
    logic [MPX_W-1:0]      mpos_done;

    assign c = item.ch;

    // Next expected heredoc character: newline, stored identifier char or quote
    always_comb
    begin
        if (mpos_reg == '0)
            expected = CH_NL;
        else if (mpos_reg <= MP_W'(dlen_reg))
            expected = CH_W'(exp_reg);
        else
            expected = CH_QUOTE;
    end

    assign mpos_inc  = MPX_W'(mpos_reg) + MPX_W'(1);
    assign mpos_done = MPX_W'(dlen_reg) + MPX_W'(2);
    assign dlen_cur  = (phase_reg == PH_S_OPEN) ? '0 : dlen_reg;

    // Step logic
    always_comb
    begin
        phase_next = phase_reg;
        depth_next = depth_reg;
        prev_next  = prev_reg;
        bkind_next = bkind_reg;
        dlen_next  = dlen_reg;
        mpos_next  = mpos_reg;
        mem_we     = 1'b0;
        mem_waddr  = dlen_cur[IDX_W-1:0];
        st         = ST_CONT;

        if (item.start_req)
        begin
            phase_next = PH_IDLE;
            depth_next = '0;
            prev_next  = CL_NONE;
            dlen_next  = '0;
            mpos_next  = '0;
            if (item.at_end)
                st = ST_END;
            else if (c == CH_SLASH && item.comment_allowed)
                phase_next = PH_C_OPEN;
            else if (c == CH_Q && item.string_allowed)
                phase_next = PH_S_QUOTE;
            else
                st = ST_BAD;
        end
        else if (phase_reg == PH_IDLE)
        begin
            st = ST_CONT;
        end
        else if (item.at_end)
        begin
            st = ST_END;
        end
        else
        begin
            unique case (phase_reg)
                PH_C_OPEN:
                begin
                    if (c != CH_PLUS)
                        st = ST_BAD;
                    else
                    begin
                        depth_next = DEPTH_BITS'(1);
                        prev_next  = CL_NONE;
                        phase_next = PH_C_BODY;
                    end
                end
                PH_C_BODY:
                begin
                    priority if (prev_reg == CL_SLASH && c == CH_PLUS)
                    begin
                        if (depth_reg == '1)
                            st = ST_LIMIT;
                        else
                        begin
                            depth_next = depth_reg + DEPTH_BITS'(1);
                            prev_next  = CL_NONE;
                        end
                    end
                    else if (prev_reg == CL_PLUS && c == CH_SLASH)
                    begin
                        prev_next = CL_NONE;
                        if (depth_reg <= DEPTH_BITS'(1))
                        begin
                            depth_next = '0;
                            st         = ST_COMMENT;
                        end
                        else
                            depth_next = depth_reg - DEPTH_BITS'(1);
                    end
                    else
                    begin
                        if (c == CH_SLASH)
                            prev_next = CL_SLASH;
                        else if (c == CH_PLUS)
                            prev_next = CL_PLUS;
                        else
                            prev_next = CL_NONE;
                    end
                end
                PH_S_QUOTE:
                begin
                    if (c != CH_QUOTE)
                        st = ST_BAD;
                    else
                        phase_next = PH_S_OPEN;
                end
                PH_S_OPEN, PH_S_IDENT:
                begin
                    // Bracket opener only right after q"
                    priority if (phase_reg == PH_S_OPEN && c == CH_LPAREN)
                    begin
                        bkind_next = BK_PAREN;
                        depth_next = DEPTH_BITS'(1);
                        phase_next = PH_S_BRACKET;
                    end
                    else if (phase_reg == PH_S_OPEN && c == CH_LBRACK)
                    begin
                        bkind_next = BK_BRACK;
                        depth_next = DEPTH_BITS'(1);
                        phase_next = PH_S_BRACKET;
                    end
                    else if (phase_reg == PH_S_OPEN && c == CH_LBRACE)
                    begin
                        bkind_next = BK_BRACE;
                        depth_next = DEPTH_BITS'(1);
                        phase_next = PH_S_BRACKET;
                    end
                    else if (phase_reg == PH_S_OPEN && c == CH_LANGLE)
                    begin
                        bkind_next = BK_ANGLE;
                        depth_next = DEPTH_BITS'(1);
                        phase_next = PH_S_BRACKET;
                    end
                    else
                    begin
                        // Heredoc identifier
                        dlen_next  = dlen_cur;
                        phase_next = PH_S_IDENT;
                        if (c == CH_NL)
                        begin
                            mpos_next  = MP_W'(1);
                            phase_next = PH_S_HEREDOC;
                        end
                        else if (!ident_char(c))
                            st = ST_BAD;
                        else if (dlen_cur >= DL_W'(MAX_DELIM_LEN))
                            st = ST_LIMIT;
                        else
                        begin
                            mem_we    = 1'b1;
                            dlen_next = dlen_cur + DL_W'(1);
                        end
                    end
                end
                PH_S_HEREDOC:
                begin
                    if (c == expected)
                    begin
                        mpos_next = mpos_inc[MP_W-1:0];
                        if (mpos_inc >= mpos_done)
                            st = ST_STRING;
                    end
                    else if (c == CH_NL)
                        mpos_next = MP_W'(1);
                    else
                        mpos_next = '0;
                end
                PH_S_BRACKET:
                begin
                    if (c == open_char(bkind_reg))
                    begin
                        if (depth_reg == '1)
                            st = ST_LIMIT;
                        else
                            depth_next = depth_reg + DEPTH_BITS'(1);
                    end
                    else if (c == close_char(bkind_reg))
                    begin
                        if (depth_reg <= DEPTH_BITS'(1))
                        begin
                            depth_next = '0;
                            phase_next = PH_S_CLOSEQ;
                        end
                        else
                            depth_next = depth_reg - DEPTH_BITS'(1);
                    end
                end
                PH_S_CLOSEQ:
                begin
                    st = (c == CH_QUOTE) ? ST_STRING : ST_BAD;
                end
                default:
                begin
                    st = ST_CONT;
                end
            endcase
        end

        // Any final status drops back to idle
        if (st != ST_CONT)
            phase_next = PH_IDLE;
    end

    assign status = st;

    // Store read address follows the next match position
    assign rd_pos    = mpos_next - MP_W'(1);
    assign mem_raddr = rd_pos[IDX_W-1:0];

    // Scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            depth_reg <= '0;
            prev_reg  <= CL_NONE;
            bkind_reg <= BK_PAREN;
            dlen_reg  <= '0;
            mpos_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            depth_reg <= depth_next;
            prev_reg  <= prev_next;
            bkind_reg <= bkind_next;
            dlen_reg  <= dlen_next;
            mpos_reg  <= mpos_next;
        end
    end

    // Delimiter store: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (mem_we)
                delim_mem[mem_waddr] <= c[DCH_W-1:0];
            exp_reg <= delim_mem[mem_raddr];
        end
    end

endmodule

// ===== rtl/nested_comment_string_lexer_core.sv =====
// Nesting comment and q-delimited string lexer, top level.
//
// Usage:
//   char_chan   (sink)   one character request per handshake: ch, at_end,
//                        start_req, comment_allowed, string_allowed.
//   status_chan (source) one status per request: 0 continue, 1 comment done,
//                        2 string done, 3 bad syntax, 4 end reached,
//                        5 limit exceeded. Any nonzero status ends the scan.
// A request taken into the input register is held there until the output
// register can take a result; its status is then loaded into that register.
// Throughput is one request per cycle while status_chan does not stall,
// set by the single pass through the step logic and one store read per request.
// When status_chan stalls, one more request is taken into the input
// register; char_chan.ready then drops until the output register empties.
// Reset clears the scan state to idle and empties both registers; the
// delimiter store needs no clearing since only entries of the current
// identifier are read.
// Depends on ncsl_pkg, ncsl_char_if, ncsl_status_if and ncsl_lex_engine.
module nested_comment_string_lexer_core #(
    parameter int MAX_DELIM_LEN = 32,
    parameter int DEPTH_BITS    = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    ncsl_char_if.sink      char_chan,
    ncsl_status_if.source  status_chan
);
    import ncsl_pkg::*;

    logic       in_valid_reg;
    char_item_t in_item_reg;
    logic       out_valid_reg;
    status_t    status_reg;
    logic       advance;
    logic       take;
    status_t    step_status;

    // Input register moves forward when the output register can take a result
    assign advance = in_valid_reg && (!out_valid_reg || status_chan.ready);
    assign char_chan.ready = !in_valid_reg || advance;
    assign take = char_chan.valid && char_chan.ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg.ch              <= char_chan.ch;
            in_item_reg.at_end          <= char_chan.at_end;
            in_item_reg.start_req       <= char_chan.start_req;
            in_item_reg.comment_allowed <= char_chan.comment_allowed;
            in_item_reg.string_allowed  <= char_chan.string_allowed;
        end
    end

    ncsl_lex_engine #(
        .MAX_DELIM_LEN (MAX_DELIM_LEN),
        .DEPTH_BITS    (DEPTH_BITS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .status (step_status)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (status_chan.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            status_reg <= step_status;
    end

    assign status_chan.valid  = out_valid_reg;
    assign status_chan.status = status_reg;

endmodule
